/* hw/rtl/i2crf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crf_pkg: shared types and constants
// Action codes, register addresses and the controller-to-datapath command
// bundle of the I2C register file with USB port cycler.
// ----------------------------------------------------------------------------
package i2crf_pkg;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_STOP    = 3'd1,
        ACT_READ    = 3'd2,
        ACT_WRITE   = 3'd3,
        ACT_PUBLISH = 3'd4,
        ACT_TICK    = 3'd5
    } action_t;

    localparam logic [7:0] ADDR_CMD_USB    = 8'h10;
    localparam logic [7:0] ADDR_CMD_AUX    = 8'h11;
    localparam logic [7:0] ADDR_CMD_SHDN   = 8'h12;
    localparam logic [7:0] ADDR_VERSION    = 8'hF0;
    localparam logic [7:0] VERSION_VALUE   = 8'h11;
    localparam logic [7:0] SHDN_MAGIC      = 8'hA5;
    localparam logic [7:0] READ_MISS       = 8'hFF;
    localparam logic [3:0] OFF_TICKS_RESET = 4'd6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;   // execute the item on the input channel
        logic load;   // load the result into the output register
    } ctrl_cmd_t;

    function automatic logic is_command(input logic [7:0] a);
        return (a == ADDR_CMD_USB) || (a == ADDR_CMD_AUX) || (a == ADDR_CMD_SHDN);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/i2crf_item_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crf item channels
// Valid/ready channels for bus events in and result items out.
// ----------------------------------------------------------------------------
interface i2crf_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data;
    logic [7:0] address;

    modport source (output valid, output action, output data, output address, input ready);
    modport sink   (input valid, input action, input data, input address, output ready);
endinterface

interface i2crf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] usb_enable;
    logic       aux_request;
    logic       shutdown_request;

    modport source (output valid, output read_data, output usb_enable,
                    output aux_request, output shutdown_request, input ready);
    modport sink   (input valid, input read_data, input usb_enable,
                    input aux_request, input shutdown_request, output ready);
endinterface
`default_nettype wire

/* hw/rtl/i2crf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crf_ctrl: item sequencer
// Accepts one item, lets the datapath execute it, then hands the result to
// the output register as soon as that register is free.
// ----------------------------------------------------------------------------
module i2crf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output i2crf_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Decode commands from state and handshakes
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        cmd.exec = in_valid && in_ready;
        cmd.load = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);
    end

    // Next state and output valid
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.exec)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (cmd.load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        priority if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* hw/rtl/i2crf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crf_dp: register file, pointer and port countdowns
// Command registers live in flops; the rest of the file is a memory with a
// valid bit per entry so unwritten entries read as their reset value.
// ----------------------------------------------------------------------------
module i2crf_dp #(
    parameter int REG_COUNT  = 241,
    parameter int PORT_COUNT = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire i2crf_pkg::ctrl_cmd_t cmd,
    input  wire logic [2:0]           action,
    input  wire logic [7:0]           data,
    input  wire logic [7:0]           address,
    input  wire logic                 cfg_we,
    input  wire logic [3:0]           cfg_wdata,
    output logic [7:0]                read_data,
    output logic [1:0]                usb_enable,
    output logic                      aux_request,
    output logic                      shutdown_request
);

    localparam int AW = $clog2(REG_COUNT);

    // Memory part of the file
    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [7:0]           mem_rd_reg;

    // Architectural state
    logic [7:0] ptr_reg,      ptr_next;
    logic       armed_reg,    armed_next;
    logic [7:0] cmd_usb_reg,  cmd_usb_next;
    logic [7:0] cmd_aux_reg,  cmd_aux_next;
    logic [7:0] cmd_shdn_reg, cmd_shdn_next;
    logic [3:0] ticks_reg,    ticks_next;
    logic [3:0] cnt_reg  [PORT_COUNT];
    logic [3:0] cnt_next [PORT_COUNT];

    // Read result staging
    logic       rd_use_mem_reg, rd_use_mem_next;
    logic [7:0] rd_alt_reg,     rd_alt_next;

    // Output payload
    logic [7:0] read_data_reg;
    logic [1:0] usb_enable_reg;
    logic       aux_request_reg;
    logic       shutdown_request_reg;
    logic [1:0] usb_enable_now;

    logic [AW-1:0] ptr_idx;
    logic [AW-1:0] addr_idx;
    logic          ptr_in_range;
    logic          addr_in_range;
    logic [3:0]    load_ticks;

    assign ptr_idx       = ptr_reg[AW-1:0];
    assign addr_idx      = address[AW-1:0];
    assign ptr_in_range  = {1'b0, ptr_reg} < 9'(REG_COUNT);
    assign addr_in_range = {1'b0, address} < 9'(REG_COUNT);
    assign load_ticks    = (ticks_reg == 4'd0) ? 4'd1 : ticks_reg;

    // Execute one item
    always_comb
    begin
        logic [3:0] eff;

        ptr_next        = ptr_reg;
        armed_next      = armed_reg;
        cmd_usb_next    = cmd_usb_reg;
        cmd_aux_next    = cmd_aux_reg;
        cmd_shdn_next   = cmd_shdn_reg;
        cnt_next        = cnt_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        rd_use_mem_next = rd_use_mem_reg;
        rd_alt_next     = rd_alt_reg;
        eff             = 4'd0;

        if (cmd.exec)
        begin
            rd_use_mem_next = 1'b0;
            rd_alt_next     = 8'h00;
            unique case (action)
                i2crf_pkg::ACT_START:
                begin
                    armed_next = 1'b1;
                end
                i2crf_pkg::ACT_READ:
                begin
                    ptr_next = ptr_reg + 8'd1;
                    priority if (!ptr_in_range)
                    begin
                        rd_alt_next = i2crf_pkg::READ_MISS;
                    end
                    else if (ptr_reg == i2crf_pkg::ADDR_CMD_USB)
                    begin
                        rd_alt_next = cmd_usb_reg;
                    end
                    else if (ptr_reg == i2crf_pkg::ADDR_CMD_AUX)
                    begin
                        rd_alt_next = cmd_aux_reg;
                    end
                    else if (ptr_reg == i2crf_pkg::ADDR_CMD_SHDN)
                    begin
                        rd_alt_next = cmd_shdn_reg;
                    end
                    else if (valid_reg[ptr_idx])
                    begin
                        mem_re          = 1'b1;
                        rd_use_mem_next = 1'b1;
                    end
                    else if (ptr_reg == i2crf_pkg::ADDR_VERSION)
                    begin
                        rd_alt_next = i2crf_pkg::VERSION_VALUE;
                    end
                    else
                    begin
                        rd_alt_next = 8'h00;
                    end
                end
                i2crf_pkg::ACT_WRITE:
                begin
                    if (armed_reg)
                    begin
                        ptr_next   = data;
                        armed_next = 1'b0;
                    end
                    else
                    begin
                        if (ptr_reg == i2crf_pkg::ADDR_CMD_USB)
                        begin
                            cmd_usb_next = data;
                        end
                        if (ptr_reg == i2crf_pkg::ADDR_CMD_AUX)
                        begin
                            cmd_aux_next = data;
                        end
                        if (ptr_reg == i2crf_pkg::ADDR_CMD_SHDN)
                        begin
                            cmd_shdn_next = data;
                        end
                        ptr_next = ptr_reg + 8'd1;
                    end
                end
                i2crf_pkg::ACT_PUBLISH:
                begin
                    if (addr_in_range)
                    begin
                        priority if (address == i2crf_pkg::ADDR_CMD_USB)
                        begin
                            cmd_usb_next = data;
                        end
                        else if (address == i2crf_pkg::ADDR_CMD_AUX)
                        begin
                            cmd_aux_next = data;
                        end
                        else if (address == i2crf_pkg::ADDR_CMD_SHDN)
                        begin
                            cmd_shdn_next = data;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                    end
                end
                i2crf_pkg::ACT_TICK:
                begin
                    // Start, advance and finish each port's power cycle
                    for (int p = 0; p < PORT_COUNT; p++)
                    begin
                        eff = (cmd_usb_reg[p] && (cnt_reg[p] == 4'd0)) ? load_ticks
                                                                       : cnt_reg[p];
                        if (eff != 4'd0)
                        begin
                            cnt_next[p] = eff - 4'd1;
                            if (eff == 4'd1)
                            begin
                                cmd_usb_next[p] = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    // stop and unused codes leave the state alone
                end
            endcase
        end
    end

    assign ticks_next = cfg_we ? cfg_wdata : ticks_reg;

    // Hold architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= 8'h00;
            armed_reg    <= 1'b0;
            cmd_usb_reg  <= 8'h00;
            cmd_aux_reg  <= 8'h00;
            cmd_shdn_reg <= 8'h00;
            ticks_reg    <= i2crf_pkg::OFF_TICKS_RESET;
            valid_reg    <= '0;
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                cnt_reg[p] <= 4'd0;
            end
        end
        else
        begin
            ptr_reg      <= ptr_next;
            armed_reg    <= armed_next;
            cmd_usb_reg  <= cmd_usb_next;
            cmd_aux_reg  <= cmd_aux_next;
            cmd_shdn_reg <= cmd_shdn_next;
            ticks_reg    <= ticks_next;
            cnt_reg      <= cnt_next;
            if (mem_we)
            begin
                valid_reg[addr_idx] <= 1'b1;
            end
        end
    end

    // Register file memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_idx] <= data;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[ptr_idx];
        end
    end

    // Port power status for the visible ports
    always_comb
    begin
        usb_enable_now = 2'b00;
        for (int p = 0; p < 2; p++)
        begin
            if (p < PORT_COUNT)
            begin
                usb_enable_now[p] = (cnt_reg[p] == 4'd0);
            end
        end
    end

    // Stage read source, then load the result item
    always_ff @(posedge clk)
    begin
        rd_use_mem_reg <= rd_use_mem_next;
        rd_alt_reg     <= rd_alt_next;
        if (cmd.load)
        begin
            read_data_reg        <= rd_use_mem_reg ? mem_rd_reg : rd_alt_reg;
            usb_enable_reg       <= usb_enable_now;
            aux_request_reg      <= cmd_aux_reg[0];
            shutdown_request_reg <= (cmd_shdn_reg == i2crf_pkg::SHDN_MAGIC);
        end
    end

    assign read_data        = read_data_reg;
    assign usb_enable       = usb_enable_reg;
    assign aux_request      = aux_request_reg;
    assign shutdown_request = shutdown_request_reg;

endmodule
`default_nettype wire

/* hw/rtl/i2c_register_file_with_port_cycler.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pointer-style I2C register file with USB port power cycling. Each bus
// event, publish or tick is one item and yields one result item. An item
// is executed first (register file access and pointer update; the memory
// read port registers its data), then its result moves into the output
// register once that register is free; no new item is taken until then.
// Unwritten entries read as their reset value through per-entry valid
// bits, so there is no clearing pass after reset. usb_off_ticks is to be
// written via cfg_we/cfg_wdata only while idle; the block has no check.
// ----------------------------------------------------------------------------
// i2c_register_file_with_port_cycler: top level
// Joins the item sequencer and the register file datapath.
// ----------------------------------------------------------------------------
module i2c_register_file_with_port_cycler #(
    parameter int REG_COUNT  = 241,
    parameter int PORT_COUNT = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    i2crf_in_if.sink         in_item,
    i2crf_out_if.source      out_item,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata
);

    i2crf_pkg::ctrl_cmd_t cmd;

    // Sequence items through the datapath
    i2crf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_ready  (in_item.ready),
        .out_ready (out_item.ready),
        .out_valid (out_item.valid),
        .cmd       (cmd)
    );

    // Register file, pointer and countdowns
    i2crf_dp #(
        .REG_COUNT  (REG_COUNT),
        .PORT_COUNT (PORT_COUNT)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .action           (in_item.action),
        .data             (in_item.data),
        .address          (in_item.address),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .read_data        (out_item.read_data),
        .usb_enable       (out_item.usb_enable),
        .aux_request      (out_item.aux_request),
        .shutdown_request (out_item.shutdown_request)
    );

endmodule
`default_nettype wire

/* tb/i2crf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crf_checker: result checker for the I2C register file
// Watches the bus event channel, the result channel and the config port.
// Tracks its own copy of the register file, pointer, pointer arm and port
// countdowns, predicts one result item per accepted bus event and compares
// every result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module i2crf_checker #(
    parameter int REG_COUNT  = 241,
    parameter int PORT_COUNT = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    i2crf_in_if        in_ch,
    i2crf_out_if       out_ch,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] usb_enable;
        logic       aux_request;
        logic       shutdown_request;
    } bus_result_t;

    logic [7:0]  regfile [0:255];
    logic [7:0]  ptr;
    logic        ptr_armed;
    logic [3:0]  countdown [0:PORT_COUNT-1];
    logic [3:0]  off_ticks;
    bus_result_t result_q[$];

    // Return the register file, pointer and timers to their reset contents
    function automatic void clear_model();
        for (int i = 0; i < 256; i++)
            regfile[i] = 8'h00;
        if (i2crf_pkg::ADDR_VERSION < REG_COUNT)
            regfile[i2crf_pkg::ADDR_VERSION] = i2crf_pkg::VERSION_VALUE;
        ptr       = 8'h00;
        ptr_armed = 1'b0;
        for (int p = 0; p < PORT_COUNT; p++)
            countdown[p] = 4'd0;
        off_ticks = i2crf_pkg::OFF_TICKS_RESET;
        result_q.delete();
    endfunction

    // One tick: start a countdown from a set port bit, run it down, and drop
    // the port bit on the tick that reaches zero
    function automatic void run_port_timers();
        logic [3:0] reload;
        reload = (off_ticks == 4'd0) ? 4'd1 : off_ticks;
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            if (regfile[i2crf_pkg::ADDR_CMD_USB][p] && countdown[p] == 4'd0)
                countdown[p] = reload;
            if (countdown[p] != 4'd0)
            begin
                countdown[p] = countdown[p] - 4'd1;
                if (countdown[p] == 4'd0)
                    regfile[i2crf_pkg::ADDR_CMD_USB][p] = 1'b0;
            end
        end
    endfunction

    // Apply one bus event to the tracked state and build its result item
    function automatic bus_result_t apply_bus_event(input logic [2:0] act,
                                                    input logic [7:0] dat,
                                                    input logic [7:0] adr);
        bus_result_t r;
        r = '0;
        case (act)
            i2crf_pkg::ACT_START:
                ptr_armed = 1'b1;
            i2crf_pkg::ACT_READ:
            begin
                r.read_data = (ptr < REG_COUNT) ? regfile[ptr] : i2crf_pkg::READ_MISS;
                ptr = ptr + 8'd1;
            end
            i2crf_pkg::ACT_WRITE:
            begin
                if (ptr_armed)
                begin
                    ptr       = dat;
                    ptr_armed = 1'b0;
                end
                else
                begin
                    // only the three command registers take master writes
                    if (i2crf_pkg::is_command(ptr) && ptr < REG_COUNT)
                        regfile[ptr] = dat;
                    ptr = ptr + 8'd1;
                end
            end
            i2crf_pkg::ACT_PUBLISH:
            begin
                if (adr < REG_COUNT)
                    regfile[adr] = dat;
            end
            i2crf_pkg::ACT_TICK:
                run_port_timers();
            default:
                ;
        endcase
        for (int p = 0; p < PORT_COUNT && p < 2; p++)
            r.usb_enable[p] = (countdown[p] == 4'd0);
        r.aux_request      = regfile[i2crf_pkg::ADDR_CMD_AUX][0];
        r.shutdown_request = (regfile[i2crf_pkg::ADDR_CMD_SHDN] == i2crf_pkg::SHDN_MAGIC);
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %02h, got %02h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bus_result_t want;
        if (!rst_n)
        begin
            clear_model();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // track the off time written through the config port
            if (cfg_we)
                off_ticks = cfg_wdata;

            // check the result item against the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result item with no bus event waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    compare_field("read_data", want.read_data, out_ch.read_data);
                    compare_field("usb_enable", 8'(want.usb_enable), 8'(out_ch.usb_enable));
                    compare_field("aux_request", 8'(want.aux_request),
                                  8'(out_ch.aux_request));
                    compare_field("shutdown_request", 8'(want.shutdown_request),
                                  8'(out_ch.shutdown_request));
                end
            end

            // predict the result item of each accepted bus event
            if (in_ch.valid && in_ch.ready)
                result_q.push_back(apply_bus_event(in_ch.action, in_ch.data, in_ch.address));

            pending = result_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the I2C register file with USB port cycler
// Drives bus events (start, stop, read, write, publish, tick) with random
// gaps against a randomly stalling result receiver, reprograms the port off
// time between phases while idle, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int REG_COUNT    = 241;
    localparam int PORT_COUNT   = 2;
    localparam int PHASE_ITEMS  = 400;
    localparam int PHASE_COUNT  = 5;

    // action codes the block decodes as no operation
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    int         fail_count;
    int         pending;
    int         items_sent;
    bit         gaps_on;
    bit         stalls_on;
    bit         long_hold_req;

    i2crf_in_if  in_ch ();
    i2crf_out_if out_ch ();

    always #5 clk = ~clk;

    i2c_register_file_with_port_cycler #(
        .REG_COUNT  (REG_COUNT),
        .PORT_COUNT (PORT_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_ch),
        .out_item  (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    i2crf_checker #(
        .REG_COUNT  (REG_COUNT),
        .PORT_COUNT (PORT_COUNT)
    ) result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one bus event, after an optional idle burst, and hold it until taken
    task automatic send_item(input logic [2:0] act, input logic [7:0] dat,
                             input logic [7:0] adr);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.data    <= dat;
        in_ch.address <= adr;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result item has come back
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_off_ticks(input logic [3:0] ticks);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] any_address();
        return 8'($urandom_range(0, 240));
    endfunction

    // Bias pointer loads toward the command registers and the top of the file
    function automatic logic [7:0] pick_pointer();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 8'(i2crf_pkg::ADDR_CMD_USB - 8'd1 + 8'($urandom_range(0, 4)));
        else if (sel < 7)
            return 8'($urandom_range(8'hEE, 8'hFF));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            return i2crf_pkg::SHDN_MAGIC;
        else if (sel == 1)
            return 8'($urandom_range(0, 3));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // One random burst: mostly addressed transfers and tick runs, some
    // publishes, and a share of arbitrary events
    task automatic random_burst();
        int         kind;
        int         sel;
        logic [7:0] where;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            // start, pointer byte, then a run of data reads and writes
            send_item(i2crf_pkg::ACT_START, pick_byte(), any_address());
            send_item(i2crf_pkg::ACT_WRITE, pick_pointer(), any_address());
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 1) == 0)
                    send_item(i2crf_pkg::ACT_READ, pick_byte(), any_address());
                else
                    send_item(i2crf_pkg::ACT_WRITE, pick_byte(), any_address());
            end
            if ($urandom_range(0, 2) == 0)
                send_item(i2crf_pkg::ACT_STOP, pick_byte(), any_address());
        end
        else if (kind < 75)
        begin
            repeat ($urandom_range(1, 6))
                send_item(i2crf_pkg::ACT_TICK, pick_byte(), any_address());
        end
        else if (kind < 88)
        begin
            sel = $urandom_range(0, 4);
            if (sel < 2)
                where = 8'(i2crf_pkg::ADDR_CMD_USB + 8'($urandom_range(0, 2)));
            else if (sel == 2)
                where = i2crf_pkg::ADDR_VERSION;
            else
                where = any_address();
            send_item(i2crf_pkg::ACT_PUBLISH, pick_byte(), where);
        end
        else
        begin
            send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), any_address());
        end
    endtask

    // Result receiver: random stall bursts, plus one long hold on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = 63;
                out_ch.ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                hold_left     = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [3:0] phase_ticks [0:PHASE_COUNT-1];
        int         target;
        in_ch.valid   = 1'b0;
        in_ch.action  = i2crf_pkg::ACT_STOP;
        in_ch.data    = 8'h00;
        in_ch.address = 8'h00;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        long_hold_req = 1'b0;
        items_sent    = 0;
        phase_ticks   = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 14)),
                          i2crf_pkg::OFF_TICKS_RESET};

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pointer at zero after reset: plain read of entry zero
        send_item(i2crf_pkg::ACT_READ, 8'h00, 8'h00);
        // version entry, then the first entry past the file
        send_item(i2crf_pkg::ACT_START, 8'hFF, 8'hF0);
        send_item(i2crf_pkg::ACT_WRITE, i2crf_pkg::ADDR_VERSION, 8'h00);
        send_item(i2crf_pkg::ACT_READ, 8'h00, 8'h00);
        send_item(i2crf_pkg::ACT_READ, 8'h00, 8'h00);
        // top pointer value, then wrap to zero
        send_item(i2crf_pkg::ACT_START, 8'h00, 8'h00);
        send_item(i2crf_pkg::ACT_WRITE, 8'hFF, 8'h00);
        send_item(i2crf_pkg::ACT_READ, 8'h00, 8'h00);
        send_item(i2crf_pkg::ACT_READ, 8'h00, 8'h00);
        // read while armed keeps the arm, so the next write loads the pointer
        send_item(i2crf_pkg::ACT_START, 8'h00, 8'h00);
        send_item(i2crf_pkg::ACT_READ, 8'h00, 8'h00);
        send_item(i2crf_pkg::ACT_WRITE, i2crf_pkg::ADDR_CMD_USB, 8'h00);
        send_item(i2crf_pkg::ACT_WRITE, 8'h03, 8'h00);
        send_item(i2crf_pkg::ACT_WRITE, 8'h01, 8'h00);
        send_item(i2crf_pkg::ACT_WRITE, i2crf_pkg::SHDN_MAGIC, 8'h00);
        // past the command registers: write dropped, pointer still steps
        send_item(i2crf_pkg::ACT_WRITE, 8'h5A, 8'h00);
        send_item(i2crf_pkg::ACT_STOP, 8'hFF, 8'hFF);
        send_item(i2crf_pkg::ACT_TICK, 8'h00, 8'h0F);
        send_item(i2crf_pkg::ACT_TICK, 8'h00, 8'h0F);
        // publish over the version, beyond the file, and clear shutdown
        send_item(i2crf_pkg::ACT_PUBLISH, 8'hFF, i2crf_pkg::ADDR_VERSION);
        send_item(i2crf_pkg::ACT_PUBLISH, 8'h00, 8'hFF);
        send_item(i2crf_pkg::ACT_PUBLISH, 8'h00, i2crf_pkg::ADDR_CMD_SHDN);
        send_item(ACT_SPARE6, 8'hFF, 8'hF0);
        send_item(ACT_SPARE7, 8'h00, 8'h00);
        wait_idle();

        // random phases, each under its own port off time
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_off_ticks(phase_ticks[ph]);
            if (ph == 1)
                long_hold_req = 1'b1;
            if (ph == PHASE_COUNT - 1)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                random_burst();
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* i2c_register_file_with_port_cycler.f */
hw/rtl/i2crf_pkg.sv
hw/rtl/i2crf_item_if.sv
hw/rtl/i2crf_ctrl.sv
hw/rtl/i2crf_dp.sv
hw/rtl/i2c_register_file_with_port_cycler.sv
tb/i2crf_checker.sv
tb/tb_top.sv
